@@ hw/rtl/sed_pkg.sv @@
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants of the sensor event detector
// Event codes, register indexes, reset values and the queue entry format.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int NUM_EVENTS = 7;

    localparam logic [2:0] EV_BATH   = 3'd0;
    localparam logic [2:0] EV_BED    = 3'd1;
    localparam logic [2:0] EV_ENTRY  = 3'd2;
    localparam logic [2:0] EV_BUTTON = 3'd3;
    localparam logic [2:0] EV_LATE   = 3'd4;
    localparam logic [2:0] EV_COLD   = 3'd5;
    localparam logic [2:0] EV_HOT    = 3'd6;

    typedef enum logic [2:0] {
        CFG_COLD_ON          = 3'd0,
        CFG_COLD_OFF         = 3'd1,
        CFG_HOT_ON           = 3'd2,
        CFG_HOT_OFF          = 3'd3,
        CFG_LOCKOUT_TICKS    = 3'd4,
        CFG_TICKS_PER_MINUTE = 3'd5,
        CFG_LATE_HOUR        = 3'd6
    } t_cfg_index;

    localparam logic signed [11:0] RST_COLD_ON          = 12'sd150;
    localparam logic signed [11:0] RST_COLD_OFF         = 12'sd155;
    localparam logic signed [11:0] RST_HOT_ON           = 12'sd300;
    localparam logic signed [11:0] RST_HOT_OFF          = 12'sd295;
    localparam logic [15:0]        RST_LOCKOUT_TICKS    = 16'd1500;
    localparam logic [15:0]        RST_TICKS_PER_MINUTE = 16'd4000;
    localparam logic [4:0]         RST_LATE_HOUR        = 5'd22;

    localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY    = 5'd24;

    typedef struct packed {
        logic [NUM_EVENTS-1:0] mask;
        logic [31:0]           stamp;
    } t_entry;

    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   nonempty;
        t_entry head;
    } t_head;

endpackage

@@ hw/rtl/sed_front.sv @@
// ----------------------------------------------------------------------------
// sed_front: tick classifier
// Accepts one tick per cycle while the queue has room, evaluates all event
// rules, updates the time counters and pushes fired-event words to the queue.
// ----------------------------------------------------------------------------
module sed_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_queue_full,
    input  logic                i_bath_beam,
    input  logic                i_bed_beam,
    input  logic                i_entry_beam,
    input  logic                i_button_level,
    input  logic signed [11:0]  i_temperature,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output sed_pkg::t_push      o_push
);
    import sed_pkg::*;

    logic signed [11:0] r_cold_on, r_cold_off, r_hot_on, r_hot_off;
    logic [15:0]        r_lockout_ticks, r_ticks_per_minute;
    logic [4:0]         r_late_hour;

    logic [31:0] r_tick, r_lock_start, r_minute_stamp;
    logic [5:0]  r_minute;
    logic [4:0]  r_hour;
    logic [15:0] r_subminute;
    logic [2:0]  r_beam_flags;
    logic        r_button_held, r_late_flag, r_cold_flag, r_hot_flag;

    logic [31:0] n_lock_start, n_minute_stamp;
    logic [5:0]  n_minute;
    logic [4:0]  n_hour;
    logic [15:0] n_subminute, sub_inc;
    logic [2:0]  n_beam_flags, beams;
    logic        n_button_held, n_late_flag, n_cold_flag, n_hot_flag;
    logic [NUM_EVENTS-1:0] mask;
    logic [31:0] lock_diff;
    logic        lock_over, beam_fired, accept;

    assign accept    = i_in_valid && !i_queue_full;
    assign beams     = {i_entry_beam, i_bed_beam, i_bath_beam};
    assign lock_diff = r_tick - r_lock_start;
    assign lock_over = lock_diff > {16'd0, r_lockout_ticks};
    assign sub_inc   = r_subminute + 16'd1;

    always_comb begin
        mask          = '0;
        n_beam_flags  = r_beam_flags;
        n_lock_start  = r_lock_start;
        beam_fired    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!beams[i]) begin
                if (!r_beam_flags[i]) begin
                    mask[i]         = 1'b1;
                    n_beam_flags[i] = 1'b1;
                    n_lock_start    = r_tick;
                    beam_fired      = 1'b1;
                end
            end else if (r_beam_flags[i] && lock_over && !beam_fired) begin
                n_beam_flags[i] = 1'b0;
            end
        end

        n_button_held = i_button_level;
        if (i_button_level && !r_button_held) begin
            mask[EV_BUTTON] = 1'b1;
        end

        n_late_flag = r_hour >= r_late_hour;
        if ((r_hour >= r_late_hour) && !r_late_flag) begin
            mask[EV_LATE] = 1'b1;
        end

        n_cold_flag = r_cold_flag;
        if (i_temperature < r_cold_on) begin
            mask[EV_COLD] = !r_cold_flag;
            n_cold_flag   = 1'b1;
        end else if (r_cold_flag && i_temperature > r_cold_off) begin
            n_cold_flag = 1'b0;
        end

        n_hot_flag = r_hot_flag;
        if (i_temperature > r_hot_on) begin
            mask[EV_HOT] = !r_hot_flag;
            n_hot_flag   = 1'b1;
        end else if (r_hot_flag && i_temperature < r_hot_off) begin
            n_hot_flag = 1'b0;
        end

        n_subminute    = sub_inc;
        n_minute_stamp = r_minute_stamp;
        n_minute       = r_minute;
        n_hour         = r_hour;
        if (sub_inc >= r_ticks_per_minute) begin
            n_subminute    = '0;
            n_minute_stamp = r_minute_stamp + 32'd1;
            n_minute       = r_minute + 6'd1;
            if (n_minute >= MINUTES_PER_HOUR) begin
                n_minute = '0;
                n_hour   = r_hour + 5'd1;
                if (n_hour >= HOURS_PER_DAY) begin
                    n_hour = '0;
                end
            end
        end
    end

    assign o_push.push        = accept && (mask != '0);
    assign o_push.entry.mask  = mask;
    assign o_push.entry.stamp = r_minute_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cold_on          <= RST_COLD_ON;
            r_cold_off         <= RST_COLD_OFF;
            r_hot_on           <= RST_HOT_ON;
            r_hot_off          <= RST_HOT_OFF;
            r_lockout_ticks    <= RST_LOCKOUT_TICKS;
            r_ticks_per_minute <= RST_TICKS_PER_MINUTE;
            r_late_hour        <= RST_LATE_HOUR;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_COLD_ON:          r_cold_on          <= i_cfg_data[11:0];
                CFG_COLD_OFF:         r_cold_off         <= i_cfg_data[11:0];
                CFG_HOT_ON:           r_hot_on           <= i_cfg_data[11:0];
                CFG_HOT_OFF:          r_hot_off          <= i_cfg_data[11:0];
                CFG_LOCKOUT_TICKS:    r_lockout_ticks    <= i_cfg_data;
                CFG_TICKS_PER_MINUTE: r_ticks_per_minute <= i_cfg_data;
                CFG_LATE_HOUR:        r_late_hour        <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick         <= '0;
            r_lock_start   <= '0;
            r_minute_stamp <= '0;
            r_minute       <= '0;
            r_hour         <= '0;
            r_subminute    <= '0;
            r_beam_flags   <= '0;
            r_button_held  <= 1'b0;
            r_late_flag    <= 1'b0;
            r_cold_flag    <= 1'b0;
            r_hot_flag     <= 1'b0;
        end else if (accept) begin
            r_tick         <= r_tick + 32'd1;
            r_lock_start   <= n_lock_start;
            r_minute_stamp <= n_minute_stamp;
            r_minute       <= n_minute;
            r_hour         <= n_hour;
            r_subminute    <= n_subminute;
            r_beam_flags   <= n_beam_flags;
            r_button_held  <= n_button_held;
            r_late_flag    <= n_late_flag;
            r_cold_flag    <= n_cold_flag;
            r_hot_flag     <= n_hot_flag;
        end
    end

endmodule

@@ hw/rtl/sed_queue.sv @@
// ----------------------------------------------------------------------------
// sed_queue: event word queue
// A small register queue that carries fired-event words from the front to
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sed_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sed_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output sed_pkg::t_head o_head
);
    import sed_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_pop;

    assign o_full          = r_count == CNT_W'(DEPTH);
    assign o_head.nonempty = r_count != '0;
    assign o_head.head     = r_mem[r_rd_ptr];
    assign do_pop          = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push.push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !i_push.push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/sed_back.sv @@
// ----------------------------------------------------------------------------
// sed_back: event emitter
// Walks the event word at the head of the queue in code order and presents
// one event per cycle in the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module sed_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sed_pkg::t_head i_head,
    input  logic           i_out_stall,
    output logic           o_pop,
    output logic           o_out_valid,
    output logic [2:0]     o_event_code,
    output logic [31:0]    o_event_stamp,
    output logic           o_last_event
);
    import sed_pkg::*;

    logic                  r_valid;
    logic [2:0]            r_code;
    logic [31:0]           r_stamp;
    logic                  r_last;
    logic [NUM_EVENTS-1:0] r_done;

    logic [NUM_EVENTS-1:0] pending, rest;
    logic [2:0]            sel;
    logic                  found, advance;

    assign pending = i_head.head.mask & ~r_done;

    always_comb begin
        sel   = '0;
        found = 1'b0;
        for (int i = 0; i < NUM_EVENTS; i++) begin
            if (pending[i] && !found) begin
                sel   = 3'(i);
                found = 1'b1;
            end
        end
        rest      = pending;
        rest[sel] = 1'b0;
    end

    assign advance = !r_valid || !i_out_stall;
    assign o_pop   = advance && i_head.nonempty && (rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else if (advance) begin
            r_valid <= i_head.nonempty;
            if (i_head.nonempty) begin
                if (rest == '0) begin
                    r_done <= '0;
                end else begin
                    r_done[sel] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_head.nonempty) begin
            r_code  <= sel;
            r_stamp <= i_head.head.stamp;
            r_last  <= rest == '0;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_event_code  = r_code;
    assign o_event_stamp = r_stamp;
    assign o_last_event  = r_last;

endmodule

@@ hw/rtl/sensor_event_detector_top.sv @@
// ----------------------------------------------------------------------------
// sensor_event_detector_top: tick event detector
// Front classifier, event queue and back emitter.
// ----------------------------------------------------------------------------
// The block takes one tick word per cycle while its queue has room. Each
// tick is classified combinationally and the events it fires are queued
// as one word; the emitter then delivers one event per cycle in code order
// while the output is not stalled, with the last event of a tick marked.
// A tick fires from zero up to seven events, each of which takes its own
// turn on the output channel, so the sustained tick rate is set by the
// emitter's output register. Ticks that fire nothing never occupy the queue.
// Configuration writes are always ready and take effect at the next cycle.
module sensor_event_detector_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_bath_beam,
    input  logic               i_bed_beam,
    input  logic               i_entry_beam,
    input  logic               i_button_level,
    input  logic signed [11:0] i_temperature,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_event_code,
    output logic [31:0]        o_event_stamp,
    output logic               o_last_event,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import sed_pkg::*;

    t_push push;
    t_head head;
    logic  queue_full;
    logic  pop;

    assign o_in_stall  = queue_full;
    assign o_cfg_ready = 1'b1;

    sed_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_queue_full   (queue_full),
        .i_bath_beam    (i_bath_beam),
        .i_bed_beam     (i_bed_beam),
        .i_entry_beam   (i_entry_beam),
        .i_button_level (i_button_level),
        .i_temperature  (i_temperature),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_push         (push)
    );

    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    sed_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_out_stall   (i_out_stall),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_event_code  (o_event_code),
        .o_event_stamp (o_event_stamp),
        .o_last_event  (o_last_event)
    );

endmodule
